/* rtl/uhc_pkg.sv */
// Shared types and constants for the UHC (CP949) byte stream decoder.
// No dependencies; every other file of the block imports this package.
package uhc_pkg;

  localparam logic [7:0]  LEAD_LO     = 8'h81;
  localparam logic [7:0]  LEAD_HI     = 8'hFE;
  localparam logic [7:0]  KSX_MIN     = 8'hA1;
  localparam logic [15:0] KSX_HOLE_A  = 16'hA2E6;
  localparam logic [15:0] KSX_HOLE_B  = 16'hA2E7;
  localparam logic [7:0]  ASCII_LIMIT = 8'h80;
  localparam logic [7:0]  UPPER_LO    = 8'h41;
  localparam logic [7:0]  UPPER_HI    = 8'h5A;
  localparam logic [7:0]  LOWER_LO    = 8'h61;
  localparam logic [7:0]  LOWER_HI    = 8'h7A;

  localparam logic [1:0]  COUNT_ONE   = 2'd1;
  localparam logic [1:0]  COUNT_TWO   = 2'd2;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_KSX    = 2'd1,
    KIND_EXT    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    kind_t       char_kind;
    logic [15:0] char_code;
    logic [1:0]  byte_count;
    logic        stream_done;
  } out_word_t;

  // Decoder result handed to the output stage.
  typedef struct packed {
    logic      emit;
    out_word_t word;
  } dec_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= LEAD_LO) && (b <= LEAD_HI);
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return ((b >= UPPER_LO) && (b <= UPPER_HI)) ||
           ((b >= LOWER_LO) && (b <= LOWER_HI)) ||
           ((b >= LEAD_LO) && (b <= LEAD_HI));
  endfunction

endpackage

/* rtl/uhc_in_stage.sv */
// Input register stage of the UHC decoder.
// Depends on uhc_pkg for the input word type.
module uhc_in_stage import uhc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     s1_valid,
  output in_word_t s1_word,
  input  logic     s1_take
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

/* rtl/uhc_decode.sv */
// Byte classifier and pending lead byte register of the UHC decoder.
// Depends on uhc_pkg for word types, kinds and byte class helpers.
module uhc_decode import uhc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_word_t s1_word,
  input  logic     s1_take,
  output dec_t     dec
);

  logic       pending_r, pending_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] b;
  logic       eos;
  logic [15:0] pair;

  assign b    = s1_word.data_byte;
  assign eos  = s1_word.end_of_stream;
  assign pair = {lead_r, b};

  always_comb begin
    dec.emit             = 1'b1;
    dec.word.char_kind   = KIND_BAD;
    dec.word.char_code   = {8'h00, b};
    dec.word.byte_count  = COUNT_ONE;
    dec.word.stream_done = eos;
    pending_nxt          = 1'b0;
    lead_nxt             = lead_r;
    if (pending_r) begin
      dec.word.char_code  = pair;
      dec.word.byte_count = COUNT_TWO;
      if (is_trail(b)) begin
        if ((lead_r >= KSX_MIN) && (b >= KSX_MIN) &&
            (pair != KSX_HOLE_A) && (pair != KSX_HOLE_B)) begin
          dec.word.char_kind = KIND_KSX;
        end else begin
          dec.word.char_kind = KIND_EXT;
        end
      end
    end else if (is_lead(b)) begin
      if (!eos) begin
        // Hold the lead byte until its trail arrives.
        dec.emit    = 1'b0;
        pending_nxt = 1'b1;
        lead_nxt    = b;
      end
    end else if (b < ASCII_LIMIT) begin
      dec.word.char_kind = KIND_SINGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      lead_r    <= 8'h00;
    end else if (s1_take) begin
      pending_r <= pending_nxt;
      lead_r    <= lead_nxt;
    end
  end

endmodule

/* rtl/uhc_out_stage.sv */
// Result register stage of the UHC decoder.
// Depends on uhc_pkg for the result word and decoder types.
module uhc_out_stage import uhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  dec_t      dec,
  output logic      s1_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      valid_r, valid_nxt;
  out_word_t word_r;
  logic      space;
  logic      load;

  assign space     = !valid_r || out_ready;
  assign s1_take   = s1_valid && (!dec.emit || space);
  assign load      = s1_valid && dec.emit && space;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= dec.word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

/* rtl/uhc_byte_stream_decoder.sv */
// Top level of the UHC (CP949) byte stream decoder.
// Depends on uhc_pkg, uhc_in_stage, uhc_decode and uhc_out_stage.
//
// This block decodes a CP949 byte stream one byte per word and delivers at
// most one character word per input byte. A lead byte (0x81 to 0xFE) is held
// internally and produces no output until the next byte pairs with it; the
// pair is reported as KS X 1001, extended UHC or invalid. ASCII bytes pass
// through as singles, while 0x80 and 0xFF are flagged invalid. When a word
// carries end_of_stream, any pending lead is resolved and the decoder starts
// fresh on the next byte. Throughput is one byte per clock while out_ready is
// high: a byte passes through an input register, a single level of
// classification logic and a result register, from which its result can be
// taken at the following edge. The only feedback is the one-byte pending lead
// register, which is updated in the same cycle a byte leaves the input
// register. Backpressure from out_ready reaches in_ready combinationally
// through the take logic of both stage registers, and a held lead byte never
// occupies the result register.
module uhc_byte_stream_decoder import uhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic     s1_valid;
  in_word_t s1_word;
  logic     s1_take;
  dec_t     dec;

  // Input register: holds one accepted byte until it is classified.
  uhc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s1_take  (s1_take)
  );

  // Classification and lead byte state, advanced only when the byte moves on.
  uhc_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_word (s1_word),
    .s1_take (s1_take),
    .dec     (dec)
  );

  // Result register: a byte that emits nothing leaves even when it is full.
  uhc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .dec       (dec),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

/* rtl/uhc_checker.sv */
// Port level checks for the UHC byte stream decoder, bound to the top level.
// Depends on uhc_pkg for the word types and kind codes.
module uhc_checker import uhc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // Single byte results carry nothing in the high byte.
  a_single_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.byte_count == COUNT_ONE) |-> out_word.char_code[15:8] == 8'h00)
    else $error("single byte result with high byte set");

  // Byte count is one or two.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.byte_count == COUNT_ONE) || (out_word.byte_count == COUNT_TWO))
    else $error("byte count out of range");

  // A KS X 1001 pair has both bytes in the upper range.
  a_ksx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.char_kind == KIND_KSX) |->
      (out_word.byte_count == COUNT_TWO) && (out_word.char_code[15:8] >= KSX_MIN) &&
      (out_word.char_code[7:0] >= KSX_MIN))
    else $error("bad KS X 1001 pair");

  // A pass-through single is ASCII of one byte.
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.char_kind == KIND_SINGLE) |->
      (out_word.byte_count == COUNT_ONE) && (out_word.char_code[7:0] < ASCII_LIMIT))
    else $error("bad single byte result");

endmodule

bind uhc_byte_stream_decoder uhc_checker u_uhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

/* verif/tb_top.sv */
// Self-checking testbench for the UHC (CP949) byte stream decoder.
// Depends on uhc_pkg for the word types and code constants, and on the
// uhc_byte_stream_decoder top level with its submodules.
`timescale 1ns / 1ps

module tb_top;
  import uhc_pkg::*;

  // A correct run ends well before this limit, which only catches a hung
  // handshake.
  localparam int CYCLE_LIMIT  = 200000;
  // The result register is loaded after the byte leaves the input register.
  // After the last expected word arrives, the run keeps watching for stray words.
  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_PERCENT = 35;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // Characters predicted from accepted bytes that have not yet come out.
  out_word_t pending_chars[$];

  // Predictor copy of the decoder's pending lead byte.
  bit         lead_held = 1'b0;
  logic [7:0] lead_val = '0;

  int mismatches = 0;
  int cycle_count = 0;

  // Idle controls. While quiet_in or quiet_out is set, that side never
  // idles. stall_request is set by a test just after a rising edge. The
  // receiver takes it at the next falling edge and counts the stall down.
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int stall_request = 0;

  uhc_byte_stream_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  // Decodes one byte against the predictor's copy of the pending lead.
  // Returns 1 when the byte completes a character. A lead byte that is held
  // for the next byte gives nothing.
  function automatic bit predict_char(input in_word_t w, output out_word_t r);
    logic [7:0]  b;
    logic [15:0] pair;
    bit          trail_ok;
    b = w.data_byte;
    r = '0;
    r.stream_done = w.end_of_stream;
    if (lead_held) begin
      // Whatever follows a lead byte is consumed with it, valid trail or not.
      pair = {lead_val, b};
      lead_held = 1'b0;
      lead_val = '0;
      trail_ok = (b >= UPPER_LO && b <= UPPER_HI) ||
                 (b >= LOWER_LO && b <= LOWER_HI) ||
                 (b >= LEAD_LO && b <= LEAD_HI);
      r.char_code = pair;
      r.byte_count = COUNT_TWO;
      if (!trail_ok) begin
        r.char_kind = KIND_BAD;
      end else if (pair[15:8] >= KSX_MIN && b >= KSX_MIN &&
                   pair != KSX_HOLE_A && pair != KSX_HOLE_B) begin
        r.char_kind = KIND_KSX;
      end else begin
        r.char_kind = KIND_EXT;
      end
      return 1'b1;
    end
    r.char_code = {8'h00, b};
    r.byte_count = COUNT_ONE;
    if (b >= LEAD_LO && b <= LEAD_HI) begin
      // A lead byte at the end of the stream has no partner and is
      // flushed as a lone invalid byte.
      if (!w.end_of_stream) begin
        lead_held = 1'b1;
        lead_val = b;
        return 1'b0;
      end
      r.char_kind = KIND_BAD;
    end else if (b < ASCII_LIMIT) begin
      r.char_kind = KIND_SINGLE;
    end else begin
      r.char_kind = KIND_BAD;
    end
    return 1'b1;
  endfunction

  // Watches both channels at the rising edge. A byte accepted on this edge
  // is predicted before the output is checked. A combinational path through
  // the block would then still meet its expectation.
  always @(posedge clk) begin : monitor
    out_word_t pred;
    out_word_t exp_word;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (predict_char(in_word, pred)) begin
          pending_chars.push_back(pred);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got kind %0d code %h count %0d done %0d",
                   $time, out_word.char_kind, out_word.char_code,
                   out_word.byte_count, out_word.stream_done);
        end else begin
          exp_word = pending_chars.pop_front();
          if (out_word.char_kind !== exp_word.char_kind) begin
            mismatches++;
            $display("%0t: char_kind expected %0d got %0d",
                     $time, exp_word.char_kind, out_word.char_kind);
          end
          if (out_word.char_code !== exp_word.char_code) begin
            mismatches++;
            $display("%0t: char_code expected %h got %h",
                     $time, exp_word.char_code, out_word.char_code);
          end
          if (out_word.byte_count !== exp_word.byte_count) begin
            mismatches++;
            $display("%0t: byte_count expected %0d got %0d",
                     $time, exp_word.byte_count, out_word.byte_count);
          end
          if (out_word.stream_done !== exp_word.stream_done) begin
            mismatches++;
            $display("%0t: stream_done expected %0d got %0d",
                     $time, exp_word.stream_done, out_word.stream_done);
          end
        end
      end
    end
  end

  // Receiver. It drops ready at random, or for a whole requested stall. The
  // stall length is counted here and not in the test that asked for it.
  always @(negedge clk) begin : receiver
    static int stall_left = 0;
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= quiet_out || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one byte and returns at the falling edge after it is accepted.
  // Valid stays high between back-to-back words. It is only lowered for an
  // idle cycle, so each falling edge drives valid once.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!quiet_in && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= {b, eos};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_pair(input logic [7:0] lead, input logic [7:0] trail,
                           input logic eos);
    send_byte(lead, 1'b0);
    send_byte(trail, eos);
  endtask

  // Stops offering bytes until every predicted character has come out.
  // At least one falling edge always passes, so the next send never drives
  // valid twice in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_chars.size() != 0);
  endtask

  function automatic logic [7:0] rand_lead();
    return 8'($urandom_range(LEAD_HI, LEAD_LO));
  endfunction

  function automatic logic [7:0] rand_trail();
    case ($urandom_range(2))
      0: return 8'($urandom_range(UPPER_HI, UPPER_LO));
      1: return 8'($urandom_range(LOWER_HI, LOWER_LO));
      default: return rand_lead();
    endcase
  endfunction

  // Mostly well-formed text: ASCII and proper lead/trail pairs with random
  // content. The rest is broken pairs, lone leads and arbitrary bytes. A
  // stray lead byte then swallows whatever comes next.
  task automatic send_random_chars(input int n);
    int   sent;
    int   pick;
    logic eos;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      eos = ($urandom_range(19) == 0);
      if (pick < 35) begin
        send_byte(8'($urandom_range(8'h7F)), eos);
        sent++;
      end else if (pick < 75) begin
        send_pair(rand_lead(), rand_trail(), eos);
        sent += 2;
      end else if (pick < 85) begin
        send_pair(rand_lead(), 8'($urandom_range(255)), eos);
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(255)), eos);
        sent++;
      end
    end
  endtask

  // Boundary bytes and each way a character can be classed.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);                 // lone invalid byte below the lead range
    send_byte(8'hFF, 1'b1);                 // lone invalid byte above the lead range
    send_pair(8'hB0, 8'hA1, 1'b0);          // ordinary KS X 1001 pair
    send_pair(8'hA1, 8'hFE, 1'b0);          // KS X 1001 at both edges
    send_pair(8'hA2, 8'hE6, 1'b0);          // first hole in the KS X 1001 area
    send_pair(8'hA2, 8'hE7, 1'b1);          // second hole, closing a stream
    send_pair(8'hFE, 8'h41, 1'b0);          // extended, upper-case trail
    send_pair(8'h81, 8'h7A, 1'b0);          // extended, lower-case trail
    send_pair(8'hA0, 8'hA1, 1'b0);          // extended, lead below 0xA1
    send_pair(8'hC8, 8'h40, 1'b0);          // bad trail just below the upper range
    send_pair(8'h81, 8'hFF, 1'b1);          // bad trail at end of stream
    send_byte(8'hFE, 1'b1);                 // lead flushed at end of stream
    wait_drained();
  endtask

  // The receiver stalls long enough that both stage registers fill and the
  // input stalls. The sender keeps offering bytes the whole time.
  task automatic test_backpressure();
    int k;
    @(posedge clk);
    stall_request = 120;
    @(negedge clk);
    for (k = 0; k < 60; k++) begin
      send_byte(8'($urandom_range(8'h7F)), ($urandom_range(9) == 0));
    end
    wait_drained();
  endtask

  task automatic test_random_streams();
    send_random_chars(1300);
    wait_drained();
  endtask

  // A long stretch with neither side idling, at full rate.
  task automatic test_full_rate();
    @(posedge clk);
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    @(negedge clk);
    send_random_chars(300);
    wait_drained();
    @(posedge clk);
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_streams();
    test_full_rate();

    // Any lead byte still held makes no word. Give the pipeline time to show
    // a word that should not be there.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
